/* hw/rtl/tle_pkg.sv */
// Shared types, character codes and key decode for the terminal line editor.
// Used by tle_dp, tle_ctrl and the top level. No dependencies.
package tle_pkg;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CTL_U = 8'h15;
	localparam logic [7:0] CH_CTL_W = 8'h17;
	localparam logic [7:0] CH_CTL_A = 8'h01;
	localparam logic [7:0] CH_CTL_E = 8'h05;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBRK  = 8'h5B; // '['
	localparam logic [7:0] CH_SS3   = 8'h4F; // 'O'
	localparam logic [7:0] CH_UP    = 8'h41; // 'A'
	localparam logic [7:0] CH_DOWN  = 8'h42; // 'B'
	localparam logic [7:0] CH_RIGHT = 8'h43; // 'C'
	localparam logic [7:0] CH_LEFT  = 8'h44; // 'D'
	localparam logic [7:0] CH_END   = 8'h46; // 'F'
	localparam logic [7:0] CH_HOME  = 8'h48; // 'H'
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_8     = 8'h38;

	localparam logic [1:0] KIND_REPAINT = 2'd0;
	localparam logic [1:0] KIND_PREV    = 2'd1;
	localparam logic [1:0] KIND_NEXT    = 2'd2;

	localparam logic [1:0] ESC_NONE  = 2'd0;
	localparam logic [1:0] ESC_SEEN  = 2'd1;
	localparam logic [1:0] ESC_CSI   = 2'd2;
	localparam logic [1:0] ESC_TILDE = 2'd3;

	typedef enum logic [3:0] {
		ACT_SET, ACT_CTRL, ACT_LEFT, ACT_RIGHT, ACT_HOME, ACT_END, ACT_HPREV,
		ACT_HNEXT, ACT_ERASE, ACT_KLINE, ACT_KWORD, ACT_INSERT
	} act_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_DECODE, OP_HIST, OP_MOVE_BS, OP_MOVE_CH, OP_SCAN_SP, OP_SCAN_WD,
		OP_SHL, OP_ERASE, OP_TAIL_CH, OP_TAIL_SP, OP_TAIL_BS, OP_SHR, OP_PUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic cur_zero;
		logic full;
		logic idx_zero;
		logic idx_at_cur;
		logic idx_at_cnt;
		logic scan_hit;
		logic shl_more;
		logic shr_more;
		logic out_free;
	} stat_t;

	function automatic act_t decode_key(input logic [1:0] esc, input logic [7:0] c);
		act_t a;
		a = ACT_SET;
		case (esc)
			ESC_SEEN, ESC_TILDE: a = ACT_SET;
			ESC_CSI: begin
				case (c)
					CH_LEFT:             a = ACT_LEFT;
					CH_RIGHT:            a = ACT_RIGHT;
					CH_UP:               a = ACT_HPREV;
					CH_DOWN:             a = ACT_HNEXT;
					CH_HOME, CH_1, CH_7: a = ACT_HOME;
					CH_END, CH_4, CH_8:  a = ACT_END;
					default:             a = ACT_SET;
				endcase
			end
			default: begin
				if (c == CH_ESC) a = ACT_SET;
				else if (c == CH_CR || c == CH_LF) a = ACT_CTRL;
				else if (c == CH_DEL || c == CH_BS) a = ACT_ERASE;
				else if (c == CH_CTL_U) a = ACT_KLINE;
				else if (c == CH_CTL_W) a = ACT_KWORD;
				else if (c == CH_CTL_A) a = ACT_HOME;
				else if (c == CH_CTL_E) a = ACT_END;
				else if (c < CH_SPACE) a = ACT_CTRL;
				else a = ACT_INSERT;
			end
		endcase
		return a;
	endfunction

	function automatic logic [1:0] esc_next(input logic [1:0] esc, input logic [7:0] c);
		logic [1:0] n;
		n = ESC_NONE;
		case (esc)
			ESC_SEEN:  n = (c == CH_LBRK || c == CH_SS3) ? ESC_CSI : ESC_NONE;
			ESC_CSI:   n = (c == CH_1 || c == CH_7 || c == CH_4 || c == CH_8) ?
			               ESC_TILDE : ESC_NONE;
			ESC_TILDE: n = ESC_NONE;
			default:   n = (c == CH_ESC) ? ESC_SEEN : ESC_NONE;
		endcase
		return n;
	endfunction

endpackage

/* hw/rtl/tle_dp.sv */
// Datapath: line buffer, cursor/count, escape state, work index and output register.
// Depends on tle_pkg; driven by tle_ctrl through cmd_t, reports through stat_t.
module tle_dp #(
	parameter int LINE_BYTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_take,
	input  logic [7:0]       in_byte,
	input  tle_pkg::cmd_t    cmd,
	output tle_pkg::stat_t   st,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic [3:0]       line_length,
	output logic [3:0]       cursor,
	output logic             edited
);
	localparam int CW = $clog2(LINE_BYTES);
	localparam int IW = $clog2(LINE_BYTES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(LINE_BYTES - 1);

	logic [7:0]    buf_q [LINE_BYTES];
	logic [CW-1:0] cnt_q, cur_q, kill_q;
	logic [CW-1:0] cnt_d, cur_d, kill_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [1:0]    ph_q, ph_d, esc_q, esc_d;
	logic          flag_q, flag_d;
	logic [7:0]    byte_q;

	logic          ov_q;
	logic [1:0]    okind_q;
	logic [7:0]    obyte_q;
	logic          olast_q;
	logic [3:0]    olen_q, ocur_q;
	logic          oflag_q;

	logic          em, em_last;
	logic [1:0]    em_kind;
	logic [7:0]    em_byte;
	logic          wr_en;
	logic [CW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;
	logic [IW:0]   shl_src;
	tle_pkg::act_t act;
	logic          full;

	assign act     = tle_pkg::decode_key(esc_q, byte_q);
	assign full    = (cnt_q == FULL_CNT);
	assign shl_src = (IW+1)'(idx_q) + (IW+1)'(kill_q);

	always_comb begin
		case (cmd.op)
			tle_pkg::OP_SCAN_SP, tle_pkg::OP_SCAN_WD: rd_addr = cur_q - CW'(1);
			tle_pkg::OP_SHL: rd_addr = shl_src[CW-1:0];
			tle_pkg::OP_SHR: rd_addr = idx_q[CW-1:0] - CW'(1);
			default:         rd_addr = idx_q[CW-1:0];
		endcase
	end
	assign rd_data = buf_q[rd_addr];

	always_comb begin
		st.act        = act;
		st.cur_zero   = (cur_q == '0);
		st.full       = full;
		st.idx_zero   = (idx_q == '0);
		st.idx_at_cur = (idx_q == IW'(cur_q));
		st.idx_at_cnt = (idx_q == IW'(cnt_q));
		st.scan_hit   = (cur_q != '0) &&
		                ((rd_data == tle_pkg::CH_SPACE) == (cmd.op == tle_pkg::OP_SCAN_SP));
		st.shl_more   = shl_src < (IW+1)'(cnt_q);
		st.shr_more   = idx_q > IW'(cur_q);
		st.out_free   = !ov_q || out_ready;
	end

	always_comb begin
		cnt_d   = cnt_q;
		cur_d   = cur_q;
		kill_d  = kill_q;
		idx_d   = idx_q;
		ph_d    = ph_q;
		esc_d   = esc_q;
		flag_d  = flag_q;
		em      = 1'b0;
		em_kind = tle_pkg::KIND_REPAINT;
		em_byte = 8'h00;
		em_last = 1'b0;
		wr_en   = 1'b0;
		wr_addr = idx_q[CW-1:0];
		wr_data = rd_data;
		if (cmd.go) begin
			case (cmd.op)
				tle_pkg::OP_DECODE: begin
					esc_d  = tle_pkg::esc_next(esc_q, byte_q);
					flag_d = !(act == tle_pkg::ACT_CTRL || (act == tle_pkg::ACT_INSERT && full));
					case (act)
						tle_pkg::ACT_LEFT: begin
							idx_d = IW'(cur_q != '0);
							cur_d = cur_q - CW'(cur_q != '0);
						end
						tle_pkg::ACT_HOME: begin
							idx_d = IW'(cur_q);
							cur_d = '0;
						end
						tle_pkg::ACT_RIGHT: begin
							idx_d = IW'(cur_q);
							cur_d = cur_q + CW'(cur_q < cnt_q);
						end
						tle_pkg::ACT_END: begin
							idx_d = IW'(cur_q);
							cur_d = cnt_q;
						end
						tle_pkg::ACT_ERASE: begin
							if (cur_q != '0) begin
								cur_d  = cur_q - CW'(1);
								kill_d = CW'(1);
								idx_d  = IW'(cur_q - CW'(1));
							end
						end
						tle_pkg::ACT_KLINE: begin
							kill_d = cur_q;
							cur_d  = '0;
							idx_d  = '0;
						end
						tle_pkg::ACT_KWORD:  kill_d = '0;
						tle_pkg::ACT_INSERT: idx_d = IW'(cnt_q);
						default: ;
					endcase
				end
				tle_pkg::OP_HIST: begin
					em      = 1'b1;
					em_kind = (byte_q == tle_pkg::CH_UP) ? tle_pkg::KIND_PREV : tle_pkg::KIND_NEXT;
					em_last = 1'b1;
				end
				tle_pkg::OP_MOVE_BS, tle_pkg::OP_TAIL_BS: begin
					em      = 1'b1;
					em_byte = tle_pkg::CH_BS;
					em_last = (idx_q == IW'(1));
					idx_d   = idx_q - IW'(1);
				end
				tle_pkg::OP_MOVE_CH: begin
					em      = 1'b1;
					em_byte = rd_data;
					em_last = ((idx_q + IW'(1)) == IW'(cur_q));
					idx_d   = idx_q + IW'(1);
				end
				tle_pkg::OP_SCAN_SP, tle_pkg::OP_SCAN_WD: begin
					if (st.scan_hit) begin
						cur_d  = cur_q - CW'(1);
						kill_d = kill_q + CW'(1);
					end
					idx_d = IW'(cur_d);
				end
				tle_pkg::OP_SHL: begin
					if (st.shl_more) begin
						wr_en = 1'b1;
						idx_d = idx_q + IW'(1);
					end else begin
						cnt_d = cnt_q - kill_q;
						idx_d = IW'(kill_q);
						ph_d  = 2'd0;
					end
				end
				tle_pkg::OP_ERASE: begin
					if (idx_q == '0) begin
						idx_d = IW'(cur_q);
					end else begin
						em      = 1'b1;
						em_byte = (ph_q == 2'd1) ? tle_pkg::CH_SPACE : tle_pkg::CH_BS;
						if (ph_q == 2'd2) begin
							ph_d  = 2'd0;
							idx_d = idx_q - IW'(1);
						end else begin
							ph_d = ph_q + 2'd1;
						end
					end
				end
				tle_pkg::OP_TAIL_CH: begin
					em      = 1'b1;
					em_byte = rd_data;
					idx_d   = idx_q + IW'(1);
				end
				tle_pkg::OP_TAIL_SP: begin
					em      = 1'b1;
					em_byte = tle_pkg::CH_SPACE;
					idx_d   = IW'(cnt_q) - IW'(cur_q) + IW'(1);
				end
				tle_pkg::OP_SHR: begin
					if (st.shr_more) begin
						wr_en = 1'b1;
						idx_d = idx_q - IW'(1);
					end
				end
				tle_pkg::OP_PUT: begin
					wr_en   = 1'b1;
					wr_addr = cur_q;
					wr_data = byte_q;
					cur_d   = cur_q + CW'(1);
					cnt_d   = cnt_q + CW'(1);
					idx_d   = IW'(cur_q) + IW'(1);
					em      = 1'b1;
					em_byte = byte_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			cur_q  <= '0;
			esc_q  <= tle_pkg::ESC_NONE;
			flag_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			cur_q  <= cur_d;
			esc_q  <= esc_d;
			flag_q <= flag_d;
			if (em) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		kill_q <= kill_d;
		idx_q  <= idx_d;
		ph_q   <= ph_d;
		if (in_take) byte_q <= in_byte;
		if (wr_en) buf_q[wr_addr] <= wr_data;
		if (em) begin
			okind_q <= em_kind;
			obyte_q <= em_byte;
			olast_q <= em_last;
			olen_q  <= 4'(cnt_d);
			ocur_q  <= 4'(cur_d);
			oflag_q <= flag_d;
		end
	end

	assign out_valid   = ov_q;
	assign out_kind    = okind_q;
	assign out_byte    = obyte_q;
	assign out_last    = olast_q;
	assign line_length = olen_q;
	assign cursor      = ocur_q;
	assign edited      = oflag_q;

endmodule

/* hw/rtl/tle_ctrl.sv */
// Controller: one-hot sequencer that steps the datapath through each key.
// Depends on tle_pkg; talks to tle_dp only through cmd_t and stat_t.
module tle_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tle_pkg::stat_t st,
	output tle_pkg::cmd_t  cmd
);
	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_DECODE  = 14'b00000000000010,
		S_HIST    = 14'b00000000000100,
		S_MOVE_BS = 14'b00000000001000,
		S_MOVE_CH = 14'b00000000010000,
		S_SCAN_SP = 14'b00000000100000,
		S_SCAN_WD = 14'b00000001000000,
		S_SHL     = 14'b00000010000000,
		S_ERASE   = 14'b00000100000000,
		S_TAIL_CH = 14'b00001000000000,
		S_TAIL_SP = 14'b00010000000000,
		S_TAIL_BS = 14'b00100000000000,
		S_SHR     = 14'b01000000000000,
		S_PUT     = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = tle_pkg::OP_IDLE;
		cmd.go  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				cmd.op = tle_pkg::OP_DECODE;
				cmd.go = 1'b1;
				case (st.act)
					tle_pkg::ACT_HPREV, tle_pkg::ACT_HNEXT: state_d = S_HIST;
					tle_pkg::ACT_LEFT, tle_pkg::ACT_HOME:    state_d = S_MOVE_BS;
					tle_pkg::ACT_RIGHT, tle_pkg::ACT_END:    state_d = S_MOVE_CH;
					tle_pkg::ACT_ERASE: state_d = st.cur_zero ? S_IDLE : S_SHL;
					tle_pkg::ACT_KLINE:  state_d = S_SHL;
					tle_pkg::ACT_KWORD:  state_d = S_SCAN_SP;
					tle_pkg::ACT_INSERT: state_d = st.full ? S_IDLE : S_SHR;
					default:             state_d = S_IDLE;
				endcase
			end
			S_HIST: begin
				cmd.op = tle_pkg::OP_HIST;
				cmd.go = st.out_free;
				if (st.out_free) state_d = S_IDLE;
			end
			S_MOVE_BS: begin
				cmd.op = tle_pkg::OP_MOVE_BS;
				if (st.idx_zero) state_d = S_IDLE;
				else cmd.go = st.out_free;
			end
			S_MOVE_CH: begin
				cmd.op = tle_pkg::OP_MOVE_CH;
				if (st.idx_at_cur) state_d = S_IDLE;
				else cmd.go = st.out_free;
			end
			S_SCAN_SP: begin
				cmd.op = tle_pkg::OP_SCAN_SP;
				cmd.go = 1'b1;
				if (!st.scan_hit) state_d = S_SCAN_WD;
			end
			S_SCAN_WD: begin
				cmd.op = tle_pkg::OP_SCAN_WD;
				cmd.go = 1'b1;
				if (!st.scan_hit) state_d = S_SHL;
			end
			S_SHL: begin
				cmd.op = tle_pkg::OP_SHL;
				cmd.go = 1'b1;
				if (!st.shl_more) state_d = S_ERASE;
			end
			S_ERASE: begin
				cmd.op = tle_pkg::OP_ERASE;
				cmd.go = st.idx_zero || st.out_free;
				if (st.idx_zero) state_d = S_TAIL_CH;
			end
			S_TAIL_CH: begin
				cmd.op = tle_pkg::OP_TAIL_CH;
				if (st.idx_at_cnt) state_d = S_TAIL_SP;
				else cmd.go = st.out_free;
			end
			S_TAIL_SP: begin
				cmd.op = tle_pkg::OP_TAIL_SP;
				cmd.go = st.out_free;
				if (st.out_free) state_d = S_TAIL_BS;
			end
			S_TAIL_BS: begin
				cmd.op = tle_pkg::OP_TAIL_BS;
				if (st.idx_zero) state_d = S_IDLE;
				else cmd.go = st.out_free;
			end
			S_SHR: begin
				cmd.op = tle_pkg::OP_SHR;
				cmd.go = 1'b1;
				if (!st.shr_more) state_d = S_PUT;
			end
			S_PUT: begin
				cmd.op = tle_pkg::OP_PUT;
				cmd.go = st.out_free;
				if (st.out_free) state_d = S_TAIL_CH;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/terminal_line_editor.sv */
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata, tuser, tlast (see ports)
//
// One key at a time: the key is accepted and decoded, then the buffer is shifted one entry
// per cycle, then the repaint bytes go out one per cycle while the output is not stalled,
// plus a step at each phase change.
// The sequencer in tle_ctrl and the single buffer read port set these steps.
// Output stalls hold the sequencer; the next key is taken while the last result waits.
// Reset clears count, cursor, escape state and edit flag; the buffer needs no clearing.
// Top level; depends on tle_pkg, tle_ctrl and tle_dp.
module terminal_line_editor #(
	parameter int LINE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [11:8] line_length, [15:12] cursor,
	                                   // [16] edited, [23:17] zero
	output logic [1:0]  m_axis_tuser,  // [1:0] out_kind
	output logic        m_axis_tlast
);
	tle_pkg::cmd_t  cmd;
	tle_pkg::stat_t st;
	logic           in_take;
	logic [7:0]     out_byte;
	logic [3:0]     line_length, cursor;
	logic           edited;

	assign in_take = s_axis_tvalid && s_axis_tready;

	tle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tle_dp #(.LINE_BYTES(LINE_BYTES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.in_byte     (s_axis_tdata),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (m_axis_tuser),
		.out_byte    (out_byte),
		.out_last    (m_axis_tlast),
		.line_length (line_length),
		.cursor      (cursor),
		.edited      (edited)
	);

	assign m_axis_tdata = {7'd0, edited, cursor, line_length, out_byte};

endmodule

/* hw/rtl/tle_checker.sv */
// Port-level checks for terminal_line_editor, attached by bind.
// Depends on the top level's port list only.
module tle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	// a result waiting on the sink must stay up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("m_axis_tvalid dropped while stalled");

	// history requests are single results with a zero byte
	a_hist_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != 2'd0 |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("history request malformed");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined result kind");

	// one key at a time: input closes right after a transfer
	a_one_key: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a key is in progress");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
		else $error("tdata padding not zero");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
